/* rtl/ceeq_pkg.sv */
// Shared constants for the coalescing error event queue.
// No dependencies.
package ceeq_pkg;
  localparam int STAGE_DEPTH_DEF = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int LEVELS          = 3;
  localparam int CODE_W          = 16;
  localparam int TIME_W          = 32;
  localparam int COUNT_W         = 10;
  localparam int DROP_W          = 4;
  localparam int BOARD_W         = 6;
  localparam int INFO_BOARD_LSB  = 16;
  localparam int INFO_COUNT_LSB  = 22;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] CMD_REPORT = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_SEND   = 2'd2;

  localparam logic [1:0] LVL_FIQ = 2'd2;

  localparam logic REG_BOARD_NUM    = 1'b0;
  localparam logic REG_DEFAULT_CODE = 1'b1;
endpackage

/* rtl/ceeq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ceeq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/coalescing_error_event_queue.sv */
// Coalescing error event queue top level: staging rings, main ring, control.
// Depends on ceeq_pkg and ceeq_ram.
//
// Channel  Direction  Payload
// in_      slave      tuser {source_level, command}, tdata {timestamp, code}
// out_     master     tuser {sent}, tdata {dropped, info_word, count, time, id}
// cfg_     write      cfg_index selects board number or default code
//
// Report and an empty Send answer from idle; a Send that pops passes S_POP.
// Update: per staged code, S_CHK and S_RD, then S_SRCH and S_CMP for each queued
// entry compared, and a final S_SRCH that appends the code when it is new; one
// more S_CHK per level. Entries are compared one at a time through the single
// read port of the main ring memory. Reset is synchronous; no clearing pass. A
// new item is taken once the previous result has been transferred or is transferring.
module coalescing_error_event_queue #(
  parameter int STAGE_DEPTH = ceeq_pkg::STAGE_DEPTH_DEF,
  parameter int QUEUE_DEPTH = ceeq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [3:0]  in_tuser,   // command[1:0], source_level[3:2]
  input  logic [47:0] in_tdata,   // code[15:0], timestamp[47:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [0:0]  out_tuser,  // sent[0]
  output logic [95:0] out_tdata,  // active_id, active_time, active_count,
                                  // info_word, dropped, zero pad
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  localparam int SW  = $clog2(STAGE_DEPTH);
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int SAW = $clog2(ceeq_pkg::LEVELS * STAGE_DEPTH);
  localparam int EW  = ceeq_pkg::CODE_W + ceeq_pkg::TIME_W + ceeq_pkg::COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_POP, S_CHK, S_RD, S_SRCH, S_CMP
  } state_t;

  state_t state_r;
  logic   out_valid_r, sent_r;
  logic [ceeq_pkg::DROP_W-1:0]  drop_r;
  logic [ceeq_pkg::CODE_W-1:0]  act_code_r, code_r, def_code_r;
  logic [ceeq_pkg::TIME_W-1:0]  act_time_r, now_r;
  logic [ceeq_pkg::COUNT_W-1:0] act_count_r;
  logic [ceeq_pkg::BOARD_W-1:0] board_r;
  logic [SW-1:0] shead_r [ceeq_pkg::LEVELS];
  logic [SW-1:0] stail_r [ceeq_pkg::LEVELS];
  logic [QW-1:0] qhead_r, qtail_r, idx_r;
  logic [1:0]    lvl_r;

  logic [1:0]  in_cmd, in_lvl;
  logic        accept;
  logic [SW-1:0] lvl_tail_nxt;

  logic           s_we;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [ceeq_pkg::CODE_W-1:0] s_rdata;
  logic           q_we;
  logic [QW-1:0]  q_waddr, q_raddr;
  logic [EW-1:0]  q_wdata, q_rdata;
  logic [ceeq_pkg::CODE_W-1:0]  q_rcode;
  logic [ceeq_pkg::TIME_W-1:0]  q_rtime;
  logic [ceeq_pkg::COUNT_W-1:0] q_rcount, q_count_inc;
  logic [QW-1:0] qtail_next;
  logic [ceeq_pkg::TIME_W-1:0] info;

  function automatic logic [SW-1:0] snext(input logic [SW-1:0] i);
    snext = (i == SW'(STAGE_DEPTH - 1)) ? '0 : i + SW'(1);
  endfunction

  function automatic logic [QW-1:0] qnext(input logic [QW-1:0] i);
    qnext = (i == QW'(QUEUE_DEPTH - 1)) ? '0 : i + QW'(1);
  endfunction

  function automatic logic [SAW-1:0] saddr(input logic [1:0] l, input logic [SW-1:0] i);
    saddr = SAW'(l) * SAW'(STAGE_DEPTH) + SAW'(i);
  endfunction

  assign in_cmd  = in_tuser[1:0];
  assign in_lvl  = in_tuser[3:2];
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept  = in_tvalid && in_tready;
  assign lvl_tail_nxt = (in_lvl < 2'(ceeq_pkg::LEVELS)) ? snext(stail_r[in_lvl]) : '0;

  assign {q_rcount, q_rtime, q_rcode} = q_rdata;
  assign q_count_inc = (q_rcount == ceeq_pkg::COUNT_MAX) ? q_rcount :
                       q_rcount + ceeq_pkg::COUNT_W'(1);
  assign qtail_next  = qnext(qtail_r);

  always_comb begin
    s_we    = accept && (in_cmd == ceeq_pkg::CMD_REPORT) &&
              (in_lvl < 2'(ceeq_pkg::LEVELS)) && (lvl_tail_nxt != shead_r[in_lvl]);
    s_waddr = (in_lvl < 2'(ceeq_pkg::LEVELS)) ? saddr(in_lvl, stail_r[in_lvl]) : '0;
    s_raddr = (lvl_r < 2'(ceeq_pkg::LEVELS)) ? saddr(lvl_r, shead_r[lvl_r]) : '0;
    q_we    = 1'b0;
    q_waddr = qtail_r;
    q_wdata = {ceeq_pkg::COUNT_W'(1), now_r, code_r};
    q_raddr = (state_r == S_IDLE) ? qhead_r : idx_r;
    case (state_r)
      S_SRCH: begin
        q_we = (idx_r == qtail_r) && (qtail_next != qhead_r);
      end
      S_CMP: begin
        q_we    = (q_rcode == code_r);
        q_waddr = idx_r;
        q_wdata = {q_count_inc, q_rtime, q_rcode};
      end
      default: begin
      end
    endcase
  end

  ceeq_ram #(.WIDTH(ceeq_pkg::CODE_W), .DEPTH(ceeq_pkg::LEVELS * STAGE_DEPTH)) u_stage_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(in_tdata[15:0]),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  ceeq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_r    <= '0;
      def_code_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ceeq_pkg::REG_BOARD_NUM:    board_r    <= cfg_wdata[ceeq_pkg::BOARD_W-1:0];
        ceeq_pkg::REG_DEFAULT_CODE: def_code_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sent_r      <= 1'b0;
      drop_r      <= '0;
      act_code_r  <= '0;
      act_time_r  <= '0;
      act_count_r <= '0;
      qhead_r     <= '0;
      qtail_r     <= '0;
      idx_r       <= '0;
      lvl_r       <= '0;
      for (int l = 0; l < ceeq_pkg::LEVELS; l++) begin
        shead_r[l] <= '0;
        stail_r[l] <= '0;
      end
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            code_r <= in_tdata[15:0];
            now_r  <= in_tdata[47:16];
            sent_r <= 1'b0;
            drop_r <= '0;
            lvl_r  <= '0;
            case (in_cmd)
              ceeq_pkg::CMD_REPORT: begin
                out_valid_r <= 1'b1;
                if (in_lvl < 2'(ceeq_pkg::LEVELS)) begin
                  if (lvl_tail_nxt == shead_r[in_lvl]) begin
                    drop_r <= ceeq_pkg::DROP_W'(1);
                  end else begin
                    stail_r[in_lvl] <= lvl_tail_nxt;
                  end
                end
              end
              ceeq_pkg::CMD_UPDATE: begin
                state_r <= S_CHK;
              end
              ceeq_pkg::CMD_SEND: begin
                if (qhead_r != qtail_r) begin
                  state_r <= S_POP;
                end else begin
                  act_code_r  <= def_code_r;
                  act_time_r  <= in_tdata[47:16];
                  act_count_r <= '0;
                  out_valid_r <= 1'b1;
                end
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        S_POP: begin
          act_code_r  <= q_rcode;
          act_time_r  <= q_rtime;
          act_count_r <= q_rcount;
          qhead_r     <= qnext(qhead_r);
          sent_r      <= 1'b1;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_CHK: begin
          if (shead_r[lvl_r] != stail_r[lvl_r]) begin
            state_r <= S_RD;
          end else if (lvl_r == ceeq_pkg::LVL_FIQ) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            lvl_r <= lvl_r + 2'd1;
          end
        end
        S_RD: begin
          code_r  <= s_rdata;
          idx_r   <= qhead_r;
          state_r <= S_SRCH;
        end
        S_SRCH: begin
          if (idx_r == qtail_r) begin
            if (qtail_next == qhead_r) begin
              drop_r <= drop_r + ceeq_pkg::DROP_W'(1);
            end else begin
              qtail_r <= qtail_next;
            end
            shead_r[lvl_r] <= snext(shead_r[lvl_r]);
            state_r        <= S_CHK;
          end else begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (q_rcode == code_r) begin
            shead_r[lvl_r] <= snext(shead_r[lvl_r]);
            state_r        <= S_CHK;
          end else begin
            idx_r   <= qnext(idx_r);
            state_r <= S_SRCH;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign info = {act_count_r, board_r, act_code_r};

  assign out_tvalid = out_valid_r;
  assign out_tuser  = sent_r;
  assign out_tdata  = {2'b00, drop_r, info, act_count_r, act_time_r, act_code_r};
endmodule

/* test/testbench.sv */
// Testbench for coalescing_error_event_queue: directed table, then random traffic.
// Checks every result against an in-bench event queue predictor; depends on ceeq_pkg.
module testbench;
  localparam int SDEPTH = ceeq_pkg::STAGE_DEPTH_DEF;
  localparam int QDEPTH = ceeq_pkg::QUEUE_DEPTH_DEF;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  level;
    logic [15:0] code;
    logic [31:0] stamp;
  } event_item_t;

  typedef struct packed {
    logic        sent;
    logic [15:0] act_id;
    logic [31:0] act_time;
    logic [9:0]  act_count;
    logic [31:0] info;
    logic [3:0]  dropped;
  } event_result_t;

  typedef struct {
    event_item_t   item;
    bit            typed;
    event_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [3:0]  in_tuser;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [0:0]  out_tuser;
  logic [95:0] out_tdata;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_wdata;

  coalescing_error_event_queue i_dut (.*);

  logic [15:0] stage_mem [ceeq_pkg::LEVELS][SDEPTH];
  int          stage_rd [ceeq_pkg::LEVELS];
  int          stage_wr [ceeq_pkg::LEVELS];
  logic [15:0] q_codes [QDEPTH];
  logic [31:0] q_times [QDEPTH];
  logic [9:0]  q_counts [QDEPTH];
  int          q_rd;
  int          q_wr;
  logic [15:0] act_code;
  logic [31:0] act_stamp;
  logic [9:0]  act_cnt;
  logic [5:0]  board_reg;
  logic [15:0] default_reg;

  event_result_t pending_results[$];
  int  error_count;
  int  result_count;
  int  sent_count;
  int  drop_count;
  bit  rx_hold;
  bit  no_idle;

  function automatic bit queue_push(logic [15:0] code, logic [31:0] stamp);
    int i;
    int nt;
    i = q_rd;
    while (i != q_wr) begin
      if (q_codes[i] == code) begin
        if (q_counts[i] != ceeq_pkg::COUNT_MAX) q_counts[i]++;
        return 0;
      end
      i = (i + 1) % QDEPTH;
    end
    nt = (q_wr + 1) % QDEPTH;
    if (nt == q_rd) return 1;
    q_codes[q_wr] = code;
    q_times[q_wr] = stamp;
    q_counts[q_wr] = 1;
    q_wr = nt;
    return 0;
  endfunction

  function automatic event_result_t predict_event(event_item_t it);
    event_result_t r;
    int nt;
    r = '0;
    case (it.command)
      ceeq_pkg::CMD_REPORT: begin
        if (it.level <= ceeq_pkg::LVL_FIQ) begin
          nt = (stage_wr[it.level] + 1) % SDEPTH;
          if (nt == stage_rd[it.level]) r.dropped = 1;
          else begin
            stage_mem[it.level][stage_wr[it.level]] = it.code;
            stage_wr[it.level] = nt;
          end
        end
      end
      ceeq_pkg::CMD_UPDATE: begin
        for (int l = 0; l < ceeq_pkg::LEVELS; l++)
          while (stage_rd[l] != stage_wr[l]) begin
            r.dropped += queue_push(stage_mem[l][stage_rd[l]], it.stamp);
            stage_rd[l] = (stage_rd[l] + 1) % SDEPTH;
          end
      end
      ceeq_pkg::CMD_SEND: begin
        if (q_rd != q_wr) begin
          act_code = q_codes[q_rd];
          act_stamp = q_times[q_rd];
          act_cnt = q_counts[q_rd];
          q_rd = (q_rd + 1) % QDEPTH;
          r.sent = 1;
        end else begin
          act_code = default_reg;
          act_cnt = 0;
          act_stamp = it.stamp;
        end
      end
      default: ;
    endcase
    r.act_id = act_code;
    r.act_time = act_stamp;
    r.act_count = act_cnt;
    r.info = {act_cnt, board_reg, act_code};
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("testbench: done, errors");
    $finish;
  end

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == ceeq_pkg::REG_BOARD_NUM) board_reg = value[5:0];
    else default_reg = value;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    wait_cycles(200);
  endtask

  task automatic send_item(event_item_t it, bit typed, event_result_t want);
    event_result_t r;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      wait_cycles($urandom_range(1, 12));
    end
    in_tvalid <= 1;
    in_tuser <= {it.level, it.command};
    in_tdata <= {it.stamp, it.code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_event(it);
    if (typed && r != want) begin
      $display("%0t table mismatch: expected %h actual %h", $time, want, r);
      error_count++;
    end
    pending_results.push_back(r);
  endtask

  task automatic stop_sending();
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  function automatic event_item_t rand_item(int code_span);
    event_item_t it;
    int k;
    k = $urandom_range(0, 99);
    it.command = k < 55 ? ceeq_pkg::CMD_REPORT : k < 75 ? ceeq_pkg::CMD_UPDATE :
                 k < 98 ? ceeq_pkg::CMD_SEND : 2'd3;
    it.level = $urandom_range(0, 19) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
    it.code = code_span == 0 ? 16'($urandom) : 16'($urandom_range(0, code_span));
    it.stamp = $urandom;
    return it;
  endfunction

  always @(posedge clk) begin
    event_result_t got;
    event_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tdata[15:0], out_tdata[47:16], out_tdata[57:48],
             out_tdata[89:58], out_tdata[93:90]};
      if (pending_results.size() == 0) begin
        $display("%0t unexpected transfer: actual %h", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          $display("%0t mismatch: expected %h actual %h", $time, want, got);
          error_count++;
        end
        result_count++;
        sent_count += got.sent;
        drop_count += got.dropped;
      end
    end
  end

  initial begin
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rx_hold) out_tready <= 0;
      else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_tready <= 0;
        wait_cycles($urandom_range(1, 12));
        out_tready <= 1;
      end else out_tready <= 1;
    end
  end

  initial begin
    stim_row_t table_rows[$];
    stim_row_t row;
    event_item_t it;
    rst_n = 0;
    in_tvalid = 0;
    in_tuser = 0;
    in_tdata = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    rx_hold = 0;
    no_idle = 0;
    error_count = 0;
    result_count = 0;
    sent_count = 0;
    drop_count = 0;
    for (int l = 0; l < ceeq_pkg::LEVELS; l++) begin
      stage_rd[l] = 0;
      stage_wr[l] = 0;
    end
    q_rd = 0;
    q_wr = 0;
    act_code = 0;
    act_stamp = 0;
    act_cnt = 0;
    board_reg = 0;
    default_reg = 0;
    wait_cycles(7);
    rst_n <= 1;
    @(posedge clk);

    // after reset: empty send, unused command, unused level
    table_rows.push_back('{'{ceeq_pkg::CMD_SEND, 2'd0, 16'h1234, 32'hFFFF_FFFF}, 1,
                          '{0, 16'h0, 32'hFFFF_FFFF, 10'd0, 32'h0, 4'd0}});
    table_rows.push_back('{'{2'd3, 2'd3, 16'hFFFF, 32'h0}, 1,
                          '{0, 16'h0, 32'hFFFF_FFFF, 10'd0, 32'h0, 4'd0}});
    table_rows.push_back('{'{ceeq_pkg::CMD_REPORT, 2'd3, 16'hFFFF, 32'h0}, 1,
                          '{0, 16'h0, 32'hFFFF_FFFF, 10'd0, 32'h0, 4'd0}});
    for (int l = 0; l < ceeq_pkg::LEVELS; l++)
      for (int k = 0; k < SDEPTH; k++)
        table_rows.push_back('{'{ceeq_pkg::CMD_REPORT, 2'(l), k == 0 ? 16'hFFFF : 16'(k),
                                 32'h0},
                              k == SDEPTH - 1,
                              '{0, 16'h0, 32'hFFFF_FFFF, 10'd0, 32'h0, 4'd1}});
    table_rows.push_back('{'{ceeq_pkg::CMD_UPDATE, 2'd0, 16'h0, 32'hFFFF_FFFF}, 1,
                          '{0, 16'h0, 32'hFFFF_FFFF, 10'd0, 32'h0, 4'd0}});
    table_rows.push_back('{'{ceeq_pkg::CMD_SEND, 2'd0, 16'h0, 32'h5}, 1,
                          '{1, 16'hFFFF, 32'hFFFF_FFFF, 10'd3, 32'h00C0_FFFF, 4'd0}});
    for (int k = 0; k < 4; k++)
      table_rows.push_back('{'{ceeq_pkg::CMD_SEND, 2'd0, 16'h0, 32'(k)}, 0, '0});

    foreach (table_rows[i]) begin
      row = table_rows[i];
      send_item(row.item, row.typed, row.want);
    end
    stop_sending();
    drain_results();

    // sweep register settings; small code ranges build coalescing and overflow
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(ceeq_pkg::REG_BOARD_NUM, 16'h3F);
          write_reg(ceeq_pkg::REG_DEFAULT_CODE, 16'hFFFF);
        end
        1: begin
          write_reg(ceeq_pkg::REG_BOARD_NUM, 16'h0);
          write_reg(ceeq_pkg::REG_DEFAULT_CODE, 16'h0);
        end
        default: begin
          write_reg(ceeq_pkg::REG_BOARD_NUM, 16'($urandom_range(0, 63)));
          write_reg(ceeq_pkg::REG_DEFAULT_CODE, 16'($urandom));
        end
      endcase
      for (int n = 0; n < 190; n++) begin
        if (phase == 2 && n == 40) begin
          fork
            begin
              rx_hold = 1;
              wait_cycles(400);
              rx_hold = 0;
            end
          join_none
        end
        if (phase == 3 && n == 100) begin
          stop_sending();
          while (pending_results.size() != 0) @(posedge clk);
        end
        if (phase == 5 && n == 120) no_idle = 1;
        it = rand_item(phase == 0 ? 0 : phase == 1 ? 3 : phase == 4 ? 40 : 20);
        send_item(it, 0, '0);
      end
      stop_sending();
      drain_results();
    end

    $display("covered %0d results, %0d pops, %0d drops over six register settings",
             result_count, sent_count, drop_count);
    if (error_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule
